// ===== rtl/i2c_eeprom_master_core_defines.svh =====
// ----------------------------------------------------------------------------
// I2C EEPROM master: assertion macros
// Shared assertion forms for the checker of the EEPROM master core.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_MASTER_CORE_DEFINES_SVH
`define I2C_EEPROM_MASTER_CORE_DEFINES_SVH

// Check a property at every clock edge outside of reset.
`define I2CEE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property at every clock edge, reset included.
`define I2CEE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/i2cee_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master package
// Payload types, command codes and register indexes of the EEPROM master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cee_pkg;

   // Command codes carried by an input item
   localparam logic [2:0] CMD_TICK         = 3'd0;
   localparam logic [2:0] CMD_RANDOM_READ  = 3'd1;
   localparam logic [2:0] CMD_CURRENT_READ = 3'd2;
   localparam logic [2:0] CMD_BYTE_WRITE   = 3'd3;
   localparam logic [2:0] CMD_ACK_POLL     = 3'd4;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_PHASE_TICKS      = 2'd0;
   localparam logic [1:0] CSR_ACK_TIMEOUT      = 2'd1;
   localparam logic [1:0] CSR_WRITE_WAIT_TICKS = 2'd2;
   localparam logic [1:0] CSR_DEVICE_ADDRESS   = 2'd3;

   localparam int unsigned CSR_DATA_WIDTH = 24;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [15:0] mem_address;
      logic [7:0]  store_byte;
      logic        sda_sample;
   } req_payload_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nack_seen;
      logic       rejected;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/i2cee_req_if.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master request channel
// Valid/ready channel that carries ticks and commands into the master.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cee_req_if;
   logic                       valid;
   logic                       ready;
   i2cee_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2cee_rsp_if.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master response channel
// Valid/ready channel that carries bus levels and status out of the master.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cee_rsp_if;
   logic                       valid;
   logic                       ready;
   i2cee_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/i2c_eeprom_master_core.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master core
// Bit-level I2C master for a serial EEPROM with 16-bit byte addresses.
// ----------------------------------------------------------------------------
// Each request item is either a tick (cmd 0, or an unknown code 5..7) that
// carries the sampled SDA level, or a command (random read, current read,
// byte write, ack poll) that starts a transaction when the master is idle and
// is flagged as rejected otherwise. Every item gives exactly one response item
// with the SCL level, the SDA pull, busy/done, the last read byte and the
// nack and rejected flags, all showing the state after that item. The block
// takes one item per clock cycle: the whole sequencer step (phase counter,
// bit shift, ack timeout, post-write count and byte plan lookup) is one pass
// of next-state logic into the state registers and the response register.
// A new item enters in the same cycle that the previous response is taken,
// so items flow back to back while the sink keeps up; a response that waits
// for rsp_chan.ready holds the input off until it is taken. Bus timing is
// counted in ticks, not clocks:
// phase_ticks ticks per bus phase (zero acts as one). The configuration
// registers reset to phase_ticks 4, ack_timeout 255, write_wait_ticks 2000
// and device_address 0x50; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_eeprom_master_core #(
   parameter int unsigned ADDRESS_WIDTH = 16
) (
   input  wire                                    clock,
   input  wire                                    reset,
   i2cee_req_if.sink                              req_chan,
   i2cee_rsp_if.source                            rsp_chan,
   input  wire                                    csr_write_enable,
   input  wire [1:0]                              csr_index,
   input  wire [i2cee_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   // Sequencer steps
   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_START_A   = 5'd1;
   localparam logic [4:0] S_START_B   = 5'd2;
   localparam logic [4:0] S_START_C   = 5'd3;
   localparam logic [4:0] S_TX_LOW    = 5'd4;
   localparam logic [4:0] S_TX_HIGH   = 5'd5;
   localparam logic [4:0] S_ACK_LOW   = 5'd6;
   localparam logic [4:0] S_ACK_HIGH  = 5'd7;
   localparam logic [4:0] S_RX_LOW    = 5'd8;
   localparam logic [4:0] S_RX_HIGH   = 5'd9;
   localparam logic [4:0] S_NACK_LOW  = 5'd10;
   localparam logic [4:0] S_NACK_HIGH = 5'd11;
   localparam logic [4:0] S_RS_LOW    = 5'd12;
   localparam logic [4:0] S_STOP_A    = 5'd13;
   localparam logic [4:0] S_STOP_B    = 5'd14;
   localparam logic [4:0] S_STOP_C    = 5'd15;
   localparam logic [4:0] S_WAIT      = 5'd16;

   // Byte plan entry kinds
   localparam logic [1:0] K_SEND    = 2'd0;
   localparam logic [1:0] K_RESTART = 2'd1;
   localparam logic [1:0] K_READ    = 2'd2;
   localparam logic [1:0] K_STOP    = 2'd3;

   // Without an address high byte the plan skips that slot
   localparam logic SKIP_HIGH = (ADDRESS_WIDTH <= 8);

   // Configuration registers
   logic [15:0] phase_ticks_ff;
   logic [7:0]  ack_timeout_ff;
   logic [23:0] write_wait_ff;
   logic [6:0]  dev_addr_ff;

   // Sequencer state
   logic [4:0]               step_ff, step_in;
   logic [15:0]              phase_ff, phase_in;
   logic [3:0]               bit_ff, bit_in;
   logic [7:0]               shift_ff, shift_in;
   logic [ADDRESS_WIDTH-1:0] addr_ff, addr_in;
   logic [7:0]               data_ff, data_in;
   logic [7:0]               capt_ff, capt_in;
   logic [2:0]               actcmd_ff, actcmd_in;
   logic [7:0]               ackw_ff, ackw_in;
   logic [23:0]              pwc_ff, pwc_in;
   logic                     nack_ff, nack_in;
   logic [2:0]               bidx_ff, bidx_in;

   // Response register
   logic                       rsp_valid_ff;
   i2cee_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   i2cee_pkg::req_payload_type req;
   logic        accept;
   logic        is_cmd;
   logic        done;
   logic        rej;
   logic [15:0] pt_eff;
   logic [15:0] phase_inc;
   logic [23:0] pwc_inc;
   logic [3:0]  bit_inc;
   logic [7:0]  ctrl_w;
   logic [7:0]  ctrl_r;
   logic [15:0] addr16;
   logic [3:0]  slot;
   logic [1:0]  plan_kind;
   logic [7:0]  plan_val;

   assign req    = req_chan.payload;
   assign accept = req_chan.valid && req_chan.ready;

   // Take a new item whenever the response slot is empty or drains this cycle
   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   assign is_cmd = (req.cmd == i2cee_pkg::CMD_RANDOM_READ)
                || (req.cmd == i2cee_pkg::CMD_CURRENT_READ)
                || (req.cmd == i2cee_pkg::CMD_BYTE_WRITE)
                || (req.cmd == i2cee_pkg::CMD_ACK_POLL);

   assign pt_eff    = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
   assign phase_inc = phase_ff + 16'd1;
   assign pwc_inc   = pwc_ff + 24'd1;
   assign bit_inc   = bit_ff + 4'd1;
   assign ctrl_w    = {dev_addr_ff, 1'b0};
   assign ctrl_r    = {dev_addr_ff, 1'b1};
   assign addr16    = 16'(addr_ff);

   // Byte plan lookup: the entry at the current byte index
   always_comb begin
      slot = {1'b0, bidx_ff};
      if (SKIP_HIGH && (bidx_ff != 3'd0)
          && ((actcmd_ff == i2cee_pkg::CMD_RANDOM_READ)
              || (actcmd_ff == i2cee_pkg::CMD_BYTE_WRITE))) begin
         slot = {1'b0, bidx_ff} + 4'd1;
      end
      plan_kind = K_STOP;
      plan_val  = 8'd0;
      unique case (actcmd_ff)
         i2cee_pkg::CMD_RANDOM_READ: begin
            unique case (slot)
               4'd0: begin plan_kind = K_SEND; plan_val = ctrl_w; end
               4'd1: begin plan_kind = K_SEND; plan_val = addr16[15:8]; end
               4'd2: begin plan_kind = K_SEND; plan_val = addr16[7:0]; end
               4'd3: plan_kind = K_RESTART;
               4'd4: begin plan_kind = K_SEND; plan_val = ctrl_r; end
               4'd5: plan_kind = K_READ;
               default: plan_kind = K_STOP;
            endcase
         end
         i2cee_pkg::CMD_CURRENT_READ: begin
            unique case (slot)
               4'd0: begin plan_kind = K_SEND; plan_val = ctrl_r; end
               4'd1: plan_kind = K_READ;
               default: plan_kind = K_STOP;
            endcase
         end
         i2cee_pkg::CMD_BYTE_WRITE: begin
            unique case (slot)
               4'd0: begin plan_kind = K_SEND; plan_val = ctrl_w; end
               4'd1: begin plan_kind = K_SEND; plan_val = addr16[15:8]; end
               4'd2: begin plan_kind = K_SEND; plan_val = addr16[7:0]; end
               4'd3: begin plan_kind = K_SEND; plan_val = data_ff; end
               default: plan_kind = K_STOP;
            endcase
         end
         i2cee_pkg::CMD_ACK_POLL: begin
            if (slot == 4'd0) begin
               plan_kind = K_SEND;
               plan_val  = ctrl_w;
            end
         end
         default: plan_kind = K_STOP;
      endcase
   end

   // Sequencer next state for the item on the request channel
   always_comb begin
      step_in   = step_ff;
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      shift_in  = shift_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      capt_in   = capt_ff;
      actcmd_in = actcmd_ff;
      ackw_in   = ackw_ff;
      pwc_in    = pwc_ff;
      nack_in   = nack_ff;
      bidx_in   = bidx_ff;
      done      = 1'b0;
      rej       = 1'b0;

      if (is_cmd) begin
         if (step_ff == S_IDLE) begin
            // Latch the command and open with a start condition
            actcmd_in = req.cmd;
            addr_in   = req.mem_address[ADDRESS_WIDTH-1:0];
            data_in   = req.store_byte;
            nack_in   = 1'b0;
            bidx_in   = 3'd0;
            phase_in  = 16'd0;
            bit_in    = 4'd0;
            ackw_in   = 8'd0;
            pwc_in    = 24'd0;
            step_in   = S_START_A;
         end else begin
            rej = 1'b1;
         end
      end else if (step_ff == S_WAIT) begin
         // Let the device program, then finish
         pwc_in = pwc_inc;
         if (pwc_inc >= write_wait_ff) begin
            done     = 1'b1;
            step_in  = S_IDLE;
            phase_in = 16'd0;
            bit_in   = 4'd0;
            ackw_in  = 8'd0;
            pwc_in   = 24'd0;
         end
      end else if (step_ff != S_IDLE) begin
         if (phase_inc < pt_eff) begin
            phase_in = phase_inc;
         end else begin
            phase_in = 16'd0;
            unique case (step_ff)
               S_START_A:  step_in = S_START_B;
               S_START_B:  step_in = S_START_C;
               S_TX_LOW:   step_in = S_TX_HIGH;
               S_TX_HIGH: begin
                  shift_in = {shift_ff[6:0], 1'b0};
                  bit_in   = bit_inc;
                  step_in  = (bit_inc >= 4'd8) ? S_ACK_LOW : S_TX_LOW;
               end
               S_ACK_LOW: begin
                  ackw_in = 8'd0;
                  step_in = S_ACK_HIGH;
               end
               S_ACK_HIGH: begin
                  if (!req.sda_sample) begin
                     ackw_in = 8'd0;
                  end else if (ackw_ff >= ack_timeout_ff) begin
                     // Give up on the ack and go to the stop
                     nack_in = 1'b1;
                     ackw_in = 8'd0;
                     step_in = S_STOP_A;
                  end else begin
                     // Retry on the next tick
                     ackw_in  = ackw_ff + 8'd1;
                     phase_in = pt_eff - 16'd1;
                  end
               end
               S_RX_LOW:   step_in = S_RX_HIGH;
               S_RX_HIGH: begin
                  shift_in = {shift_ff[6:0], req.sda_sample};
                  bit_in   = bit_inc;
                  if (bit_inc >= 4'd8) begin
                     capt_in = {shift_ff[6:0], req.sda_sample};
                     step_in = S_NACK_LOW;
                  end else begin
                     step_in = S_RX_LOW;
                  end
               end
               S_NACK_LOW: step_in = S_NACK_HIGH;
               S_RS_LOW:   step_in = S_START_A;
               S_STOP_A:   step_in = S_STOP_B;
               S_STOP_B:   step_in = S_STOP_C;
               S_STOP_C: begin
                  if ((actcmd_ff == i2cee_pkg::CMD_BYTE_WRITE) && !nack_ff
                      && (write_wait_ff != 24'd0)) begin
                     pwc_in  = 24'd0;
                     step_in = S_WAIT;
                  end else begin
                     done     = 1'b1;
                     step_in  = S_IDLE;
                     bit_in   = 4'd0;
                     ackw_in  = 8'd0;
                     pwc_in   = 24'd0;
                  end
               end
               S_START_C, S_NACK_HIGH: ;
               default: begin
                  done     = 1'b1;
                  step_in  = S_IDLE;
                  bit_in   = 4'd0;
                  ackw_in  = 8'd0;
                  pwc_in   = 24'd0;
               end
            endcase

            // Advance to the next plan entry after a start, an acked byte
            // or the master NACK
            if ((step_ff == S_START_C) || (step_ff == S_NACK_HIGH)
                || ((step_ff == S_ACK_HIGH) && !req.sda_sample)) begin
               bit_in = 4'd0;
               if (bidx_ff != 3'd7) begin
                  bidx_in = bidx_ff + 3'd1;
               end
               unique case (plan_kind)
                  K_SEND: begin
                     shift_in = plan_val;
                     step_in  = S_TX_LOW;
                  end
                  K_RESTART: step_in = S_RS_LOW;
                  K_READ: begin
                     shift_in = 8'd0;
                     step_in  = S_RX_LOW;
                  end
                  default: step_in = S_STOP_A;
               endcase
            end
         end
      end
   end

   // Bus levels and status after the item
   always_comb begin
      rsp_data_in.scl_level    = 1'b1;
      rsp_data_in.sda_pull_low = 1'b0;
      unique case (step_in)
         S_START_B, S_STOP_B: begin
            rsp_data_in.scl_level    = 1'b1;
            rsp_data_in.sda_pull_low = 1'b1;
         end
         S_START_C, S_STOP_A: begin
            rsp_data_in.scl_level    = 1'b0;
            rsp_data_in.sda_pull_low = 1'b1;
         end
         S_TX_LOW: begin
            rsp_data_in.scl_level    = 1'b0;
            rsp_data_in.sda_pull_low = !shift_in[7];
         end
         S_TX_HIGH: begin
            rsp_data_in.scl_level    = 1'b1;
            rsp_data_in.sda_pull_low = !shift_in[7];
         end
         S_ACK_LOW, S_RX_LOW, S_NACK_LOW, S_RS_LOW: begin
            rsp_data_in.scl_level    = 1'b0;
            rsp_data_in.sda_pull_low = 1'b0;
         end
         default: begin
            rsp_data_in.scl_level    = 1'b1;
            rsp_data_in.sda_pull_low = 1'b0;
         end
      endcase
      rsp_data_in.busy_res  = (step_in != S_IDLE);
      rsp_data_in.done_res  = done;
      rsp_data_in.read_data = capt_in;
      rsp_data_in.nack_seen = nack_in;
      rsp_data_in.rejected  = rej;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= 16'd4;
         ack_timeout_ff <= 8'd255;
         write_wait_ff  <= 24'd2000;
         dev_addr_ff    <= 7'h50;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            i2cee_pkg::CSR_PHASE_TICKS:      phase_ticks_ff <= csr_wdata[15:0];
            i2cee_pkg::CSR_ACK_TIMEOUT:      ack_timeout_ff <= csr_wdata[7:0];
            i2cee_pkg::CSR_WRITE_WAIT_TICKS: write_wait_ff  <= csr_wdata[23:0];
            i2cee_pkg::CSR_DEVICE_ADDRESS:   dev_addr_ff    <= csr_wdata[6:0];
         endcase
      end
   end

   // Sequencer state: advance once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= S_IDLE;
         phase_ff  <= 16'd0;
         bit_ff    <= 4'd0;
         shift_ff  <= 8'd0;
         addr_ff   <= '0;
         data_ff   <= 8'd0;
         capt_ff   <= 8'd0;
         actcmd_ff <= i2cee_pkg::CMD_TICK;
         ackw_ff   <= 8'd0;
         pwc_ff    <= 24'd0;
         nack_ff   <= 1'b0;
         bidx_ff   <= 3'd0;
      end else if (accept) begin
         step_ff   <= step_in;
         phase_ff  <= phase_in;
         bit_ff    <= bit_in;
         shift_ff  <= shift_in;
         addr_ff   <= addr_in;
         data_ff   <= data_in;
         capt_ff   <= capt_in;
         actcmd_ff <= actcmd_in;
         ackw_ff   <= ackw_in;
         pwc_ff    <= pwc_in;
         nack_ff   <= nack_in;
         bidx_ff   <= bidx_in;
      end
   end

   // Response register: load on accept, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/i2cee_checker.sv =====
// ----------------------------------------------------------------------------
// I2C EEPROM master checker
// Port-level checks on the response channel of the EEPROM master core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_eeprom_master_core_defines.svh"

module i2cee_checker (
   input wire clock,
   input wire reset,
   input wire rsp_valid,
   input wire rsp_ready,
   input wire scl_level,
   input wire sda_pull_low,
   input wire busy_res,
   input wire done_res,
   input wire rejected
);

   // A response waiting for the sink stays offered
   `I2CEE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")

   // Nothing is offered right after reset
   `I2CEE_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "response offered after reset")

   // A command can only be turned away while a transaction runs
   `I2CEE_ASSERT(a_rej_busy, clock, reset, rsp_valid && rejected |-> busy_res, "rejected while idle")

   // A finished transaction leaves the master idle
   `I2CEE_ASSERT(a_done_idle, clock, reset, rsp_valid && done_res |-> !busy_res, "done while busy")

   // An idle master leaves the bus released
   `I2CEE_ASSERT(a_idle_bus, clock, reset, rsp_valid && !busy_res |-> scl_level && !sda_pull_low, "bus driven while idle")

endmodule

bind i2c_eeprom_master_core i2cee_checker u_i2cee_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .scl_level    (rsp_chan.payload.scl_level),
   .sda_pull_low (rsp_chan.payload.sda_pull_low),
   .busy_res     (rsp_chan.payload.busy_res),
   .done_res     (rsp_chan.payload.done_res),
   .rejected     (rsp_chan.payload.rejected)
);

`default_nettype wire
